[hw/rtl/imrs_pkg.sv]
package imrs_pkg;

    // Request codes carried by req_type.
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Sequence modes reported on the mode output.
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_MOVING = 2'd1;
    localparam logic [1:0] MODE_DWELL  = 2'd2;

    // Limits applied to a start request.
    localparam logic [15:0] MAX_REPEATS      = 16'd99;
    localparam logic [15:0] MAX_DWELL_MS     = 16'd30000;
    localparam logic [15:0] MAX_ANGLE_TENTHS = 16'd36000;

    localparam logic [15:0] ANGLE_RESET = 16'd100;
    localparam logic [7:0]  GRACE_RESET = 8'd50;

    // Configuration register map.
    localparam int unsigned PADDR_W        = 3;
    localparam logic        REG_GRACE_TICKS = 1'b0;

    // The progress quotient never exceeds the stored angle, so one quotient
    // bit per angle bit is enough.
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic load;
        logic diff;
        logic mag;
        logic mul;
        logic div_init;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } sts_t;

endpackage

[hw/rtl/imrs_ctrl.sv]
module imrs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  imrs_pkg::sts_t   sts,
    output imrs_pkg::cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MAG,
        S_MUL,
        S_PREP,
        S_DIV,
        S_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = sts.need_div ? S_MAG : S_COMMIT;
            end
            S_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                // The result is committed only once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/imrs_dp.sv]
module imrs_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  imrs_pkg::cmd_t       cmd,
    output imrs_pkg::sts_t       sts,
    input  logic [7:0]           grace_ticks,
    input  logic [1:0]           req_type,
    input  logic [15:0]          angle_tenths,
    input  logic [23:0]          step_count,
    input  logic                 direction_ccw,
    input  logic [15:0]          repeat_request,
    input  logic [15:0]          dwell_request_ms,
    input  logic                 controller_idle,
    input  logic                 motion_allowed,
    input  logic                 stepper_present,
    input  logic signed [31:0]   motor_position,
    input  logic                 motor_running,
    output logic [1:0]           mode,
    output logic                 move_strobe,
    output logic signed [24:0]   move_steps_signed,
    output logic                 driver_enabled,
    output logic [15:0]          progress_tenths,
    output logic [6:0]           moves_done,
    output logic [31:0]          moves_total,
    output logic                 finished,
    output logic                 rejected
);

    // Captured transfer.
    logic [1:0]  req_reg;
    logic [15:0] angle_in_reg;
    logic [23:0] count_reg;
    logic        ccw_reg;
    logic [15:0] rep_reg;
    logic [15:0] dwell_in_reg;
    logic        ctl_idle_reg;
    logic        allowed_reg;
    logic        present_reg;
    logic [31:0] pos_reg;
    logic        running_reg;

    // Sequencer state.
    logic [1:0]  mode_reg,           mode_next;
    logic [15:0] angle_store_reg,    angle_store_next;
    logic [24:0] signed_steps_reg,   signed_steps_next;
    logic [23:0] move_length_reg,    move_length_next;
    logic [31:0] start_pos_reg,      start_pos_next;
    logic [6:0]  repeat_target_reg,  repeat_target_next;
    logic [6:0]  repeat_done_reg,    repeat_done_next;
    logic [14:0] dwell_length_reg,   dwell_length_next;
    logic [14:0] dwell_left_reg,     dwell_left_next;
    logic [7:0]  grace_left_reg,     grace_left_next;
    logic [15:0] progress_reg,       progress_next;
    logic [31:0] total_reg,          total_next;
    logic        enable_reg,         enable_next;

    // Progress arithmetic.
    logic [32:0] diff_reg;
    logic [23:0] moved_reg;
    logic [39:0] prod_reg;
    logic [23:0] rem_reg,   rem_next;
    logic [15:0] quo_reg;
    logic [imrs_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic [32:0] diff_abs;
    logic [23:0] moved_sat;
    logic [39:0] prod_c;
    logic [24:0] trial;
    logic [24:0] trial_sub;
    logic        trial_ge;

    // Output register.
    logic [1:0]  mode_out_reg;
    logic        strobe_out_reg;
    logic [24:0] steps_out_reg;
    logic        enable_out_reg;
    logic [15:0] progress_out_reg;
    logic [6:0]  done_out_reg;
    logic [31:0] total_out_reg;
    logic        fin_out_reg;
    logic        rej_out_reg;

    logic        strobe;
    logic        fin;
    logic        rej;
    logic        do_begin;
    logic        start_bad;
    logic [24:0] steps_new;
    logic [24:0] steps_neg;
    logic [23:0] mag;
    logic [14:0] dwell_dec;
    logic [7:0]  grace_dec;
    logic [6:0]  done_inc;
    logic        grace_past;
    logic        motor_stopped;
    logic        move_done;

    assign sts.need_div = (req_reg == imrs_pkg::REQ_TICK) && (mode_reg == imrs_pkg::MODE_MOVING)
                          && present_reg && (move_length_reg != 24'd0);
    assign sts.div_last = (div_cnt_reg == imrs_pkg::DIV_CNT_W'(imrs_pkg::DIV_STEPS - 1));

    assign diff_abs  = diff_reg[32] ? (~diff_reg + 33'd1) : diff_reg;
    assign moved_sat = (diff_abs > {9'd0, move_length_reg}) ? move_length_reg : diff_abs[23:0];
    assign prod_c    = moved_reg * angle_store_reg;

    // Restoring division: the remainder starts below the divisor, so each
    // trial value stays below twice the divisor and one subtract suffices.
    assign trial     = {rem_reg, quo_reg[15]};
    assign trial_sub = trial - {1'b0, move_length_reg};
    assign trial_ge  = (trial >= {1'b0, move_length_reg});
    assign rem_next  = trial_ge ? trial_sub[23:0] : trial[23:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg      <= req_type;
            angle_in_reg <= angle_tenths;
            count_reg    <= step_count;
            ccw_reg      <= direction_ccw;
            rep_reg      <= repeat_request;
            dwell_in_reg <= dwell_request_ms;
            ctl_idle_reg <= controller_idle;
            allowed_reg  <= motion_allowed;
            present_reg  <= stepper_present;
            pos_reg      <= motor_position;
            running_reg  <= motor_running;
        end
        if (cmd.diff)
        begin
            diff_reg <= {pos_reg[31], pos_reg} - {start_pos_reg[31], start_pos_reg};
        end
        if (cmd.mag)
        begin
            moved_reg <= moved_sat;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_c;
        end
        if (cmd.div_init)
        begin
            rem_reg     <= prod_reg[39:16];
            quo_reg     <= prod_reg[15:0];
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_next;
            quo_reg     <= {quo_reg[14:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.commit)
        begin
            mode_out_reg     <= mode_next;
            strobe_out_reg   <= strobe;
            steps_out_reg    <= strobe ? signed_steps_next : 25'd0;
            enable_out_reg   <= enable_next;
            progress_out_reg <= progress_next;
            done_out_reg     <= repeat_done_next;
            total_out_reg    <= total_next;
            fin_out_reg      <= fin;
            rej_out_reg      <= rej;
        end
    end

    always_comb
    begin
        mode_next          = mode_reg;
        angle_store_next   = angle_store_reg;
        signed_steps_next  = signed_steps_reg;
        move_length_next   = move_length_reg;
        start_pos_next     = start_pos_reg;
        repeat_target_next = repeat_target_reg;
        repeat_done_next   = repeat_done_reg;
        dwell_length_next  = dwell_length_reg;
        dwell_left_next    = dwell_left_reg;
        grace_left_next    = grace_left_reg;
        progress_next      = progress_reg;
        total_next         = total_reg;
        enable_next        = enable_reg;
        strobe             = 1'b0;
        fin                = 1'b0;
        rej                = 1'b0;
        do_begin           = 1'b0;

        start_bad = (mode_reg != imrs_pkg::MODE_IDLE) || !ctl_idle_reg || !allowed_reg
                    || !present_reg || (angle_in_reg == 16'd0)
                    || (angle_in_reg > imrs_pkg::MAX_ANGLE_TENTHS) || (count_reg == 24'd0);
        steps_new   = ccw_reg ? (~{1'b0, count_reg} + 25'd1) : {1'b0, count_reg};
        dwell_dec   = (dwell_left_reg != 15'd0) ? (dwell_left_reg - 15'd1) : dwell_left_reg;
        grace_dec   = (grace_left_reg != 8'd0) ? (grace_left_reg - 8'd1) : grace_left_reg;
        grace_past  = (grace_dec == 8'd0);
        motor_stopped = present_reg && !running_reg;
        move_done   = (move_length_reg != 24'd0) ? (grace_past && motor_stopped)
                                                 : (grace_past && (!present_reg || motor_stopped));
        done_inc    = repeat_done_reg + 7'd1;

        case (req_reg)
            imrs_pkg::REQ_START:
            begin
                if (start_bad)
                begin
                    rej = 1'b1;
                end
                else
                begin
                    angle_store_next  = angle_in_reg;
                    signed_steps_next = steps_new;
                    if (rep_reg == 16'd0)
                    begin
                        repeat_target_next = 7'd1;
                    end
                    else if (rep_reg > imrs_pkg::MAX_REPEATS)
                    begin
                        repeat_target_next = imrs_pkg::MAX_REPEATS[6:0];
                    end
                    else
                    begin
                        repeat_target_next = rep_reg[6:0];
                    end
                    repeat_done_next  = 7'd0;
                    dwell_length_next = (dwell_in_reg > imrs_pkg::MAX_DWELL_MS)
                                        ? imrs_pkg::MAX_DWELL_MS[14:0] : dwell_in_reg[14:0];
                    dwell_left_next   = 15'd0;
                    do_begin          = 1'b1;
                end
            end
            imrs_pkg::REQ_CLEAR:
            begin
                progress_next      = 16'd0;
                total_next         = 32'd0;
                move_length_next   = 24'd0;
                signed_steps_next  = 25'd0;
                repeat_target_next = 7'd1;
                repeat_done_next   = 7'd0;
                dwell_length_next  = 15'd0;
                dwell_left_next    = 15'd0;
                grace_left_next    = 8'd0;
                if (mode_reg == imrs_pkg::MODE_DWELL)
                begin
                    mode_next = imrs_pkg::MODE_MOVING;
                end
            end
            imrs_pkg::REQ_TICK:
            begin
                if (mode_reg == imrs_pkg::MODE_DWELL)
                begin
                    if (!present_reg)
                    begin
                        repeat_done_next = repeat_target_reg;
                        mode_next        = imrs_pkg::MODE_IDLE;
                        fin              = 1'b1;
                    end
                    else
                    begin
                        dwell_left_next = dwell_dec;
                        do_begin        = (dwell_dec == 15'd0);
                    end
                end
                else if (mode_reg == imrs_pkg::MODE_MOVING)
                begin
                    if (present_reg && (move_length_reg != 24'd0))
                    begin
                        progress_next = quo_reg;
                    end
                    grace_left_next = grace_dec;
                    if (move_done)
                    begin
                        progress_next    = angle_store_reg;
                        total_next       = total_reg + 32'd1;
                        repeat_done_next = done_inc;
                        if ((done_inc < repeat_target_reg) && present_reg)
                        begin
                            if (dwell_length_reg != 15'd0)
                            begin
                                enable_next     = 1'b0;
                                dwell_left_next = dwell_length_reg;
                                mode_next       = imrs_pkg::MODE_DWELL;
                            end
                            else
                            begin
                                do_begin = 1'b1;
                            end
                        end
                        else
                        begin
                            mode_next = imrs_pkg::MODE_IDLE;
                            fin       = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // Launch of one move: it always comes last, after the step count is settled.
        steps_neg = ~signed_steps_next + 25'd1;
        mag       = signed_steps_next[24] ? steps_neg[23:0] : signed_steps_next[23:0];
        if (do_begin)
        begin
            progress_next    = 16'd0;
            start_pos_next   = pos_reg;
            enable_next      = 1'b1;
            move_length_next = mag;
            grace_left_next  = grace_ticks;
            mode_next        = imrs_pkg::MODE_MOVING;
            strobe           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= imrs_pkg::MODE_IDLE;
            angle_store_reg   <= imrs_pkg::ANGLE_RESET;
            signed_steps_reg  <= 25'd0;
            move_length_reg   <= 24'd0;
            start_pos_reg     <= 32'd0;
            repeat_target_reg <= 7'd1;
            repeat_done_reg   <= 7'd0;
            dwell_length_reg  <= 15'd0;
            dwell_left_reg    <= 15'd0;
            grace_left_reg    <= 8'd0;
            progress_reg      <= 16'd0;
            total_reg         <= 32'd0;
            enable_reg        <= 1'b0;
        end
        else if (cmd.commit)
        begin
            mode_reg          <= mode_next;
            angle_store_reg   <= angle_store_next;
            signed_steps_reg  <= signed_steps_next;
            move_length_reg   <= move_length_next;
            start_pos_reg     <= start_pos_next;
            repeat_target_reg <= repeat_target_next;
            repeat_done_reg   <= repeat_done_next;
            dwell_length_reg  <= dwell_length_next;
            dwell_left_reg    <= dwell_left_next;
            grace_left_reg    <= grace_left_next;
            progress_reg      <= progress_next;
            total_reg         <= total_next;
            enable_reg        <= enable_next;
        end
    end

    assign mode              = mode_out_reg;
    assign move_strobe       = strobe_out_reg;
    assign move_steps_signed = steps_out_reg;
    assign driver_enabled    = enable_out_reg;
    assign progress_tenths   = progress_out_reg;
    assign moves_done        = done_out_reg;
    assign moves_total       = total_out_reg;
    assign finished          = fin_out_reg;
    assign rejected          = rej_out_reg;

endmodule

[hw/rtl/indexed_move_repeat_sequencer_unit.sv]
// Indexed move repeat sequencer. Each input transfer (start, one-millisecond
// tick or counter reset) yields exactly one result transfer with the mode,
// the move command, the driver enable, the move progress and the counters.
// A transfer is taken only while the unit is idle; a finished result waits in
// an output register, so the next transfer can be taken before the result is
// picked up. An item passes the load, difference and commit states; a tick
// during a move with a stepper present and a nonzero move length goes through
// a difference, saturation and multiply stage and a 16-step restoring divider
// that forms moved * angle / move_length before its commit. The only register,
// grace_ticks (reset 50), sits at address 0 of the APB port; the user must
// write it only while the unit is idle; the unit does not enforce this.
module indexed_move_repeat_sequencer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [imrs_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [15:0]                   angle_tenths,
    input  logic [23:0]                   step_count,
    input  logic                          direction_ccw,
    input  logic [15:0]                   repeat_request,
    input  logic [15:0]                   dwell_request_ms,
    input  logic                          controller_idle,
    input  logic                          motion_allowed,
    input  logic                          stepper_present,
    input  logic signed [31:0]            motor_position,
    input  logic                          motor_running,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    mode,
    output logic                          move_strobe,
    output logic signed [24:0]            move_steps_signed,
    output logic                          driver_enabled,
    output logic [15:0]                   progress_tenths,
    output logic [6:0]                    moves_done,
    output logic [31:0]                   moves_total,
    output logic                          finished,
    output logic                          rejected
);

    imrs_pkg::cmd_t cmd;
    imrs_pkg::sts_t sts;

    logic [7:0] grace_reg;
    logic [7:0] grace_next;
    logic       grace_sel;

    assign pready    = 1'b1;
    assign grace_sel = (paddr[2] == imrs_pkg::REG_GRACE_TICKS);

    always_comb
    begin
        grace_next = grace_reg;
        if (psel && penable && pwrite && pready && grace_sel)
        begin
            grace_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg <= imrs_pkg::GRACE_RESET;
        end
        else
        begin
            grace_reg <= grace_next;
        end
    end

    assign prdata = grace_sel ? {24'd0, grace_reg} : 32'd0;

    imrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    imrs_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .grace_ticks       (grace_reg),
        .req_type          (req_type),
        .angle_tenths      (angle_tenths),
        .step_count        (step_count),
        .direction_ccw     (direction_ccw),
        .repeat_request    (repeat_request),
        .dwell_request_ms  (dwell_request_ms),
        .controller_idle   (controller_idle),
        .motion_allowed    (motion_allowed),
        .stepper_present   (stepper_present),
        .motor_position    (motor_position),
        .motor_running     (motor_running),
        .mode              (mode),
        .move_strobe       (move_strobe),
        .move_steps_signed (move_steps_signed),
        .driver_enabled    (driver_enabled),
        .progress_tenths   (progress_tenths),
        .moves_done        (moves_done),
        .moves_total       (moves_total),
        .finished          (finished),
        .rejected          (rejected)
    );

endmodule
